// ===== hw/rtl/charge_trend_detector_unit_macros.svh =====
// Assertion helpers for the charge trend detector checker.
// Both expect signals named clock and reset in the scope where they are used.
`ifndef CHARGE_TREND_DETECTOR_UNIT_MACROS_SVH
`define CHARGE_TREND_DETECTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("charge trend detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define CTD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("charge trend detector check failed");

`endif

// ===== hw/rtl/ctd_pkg.sv =====
package ctd_pkg;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_HOST = 2'd1,
      OP_AUTO = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_BLINK_PERIOD   = 3'd0,
      REG_PERCENT_PERIOD = 3'd1,
      REG_SAMPLE_PERIOD  = 3'd2,
      REG_GUARD          = 3'd3,
      REG_STOP_HOLD      = 3'd4,
      REG_RISE_THRESHOLD = 3'd5
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [15:0] BLINK_PERIOD_RESET   = 16'd500;
   localparam logic [15:0] PERCENT_PERIOD_RESET = 16'd2000;
   localparam logic [15:0] SAMPLE_PERIOD_RESET  = 16'd1000;
   localparam logic [15:0] GUARD_RESET          = 16'd5000;
   localparam logic [15:0] STOP_HOLD_RESET      = 16'd10000;
   localparam logic [15:0] RISE_THRESHOLD_RESET = 16'd20;

   localparam logic [7:0] PERCENT_MAX  = 8'd100;
   localparam logic [7:0] PERCENT_NONE = 8'hFF;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic        enable;
      logic [15:0] voltage_mv;
      logic [7:0]  battery_percent;
   } ctd_req_type;

   typedef struct packed {
      logic       charging;
      logic       bolt_bright;
      logic       percent_update;
      logic [6:0] percent_value;
   } ctd_rsp_type;

   typedef struct packed {
      logic [15:0]        blink_period_ms;
      logic [15:0]        percent_period_ms;
      logic [15:0]        sample_period_ms;
      logic [15:0]        guard_ms;
      logic [15:0]        stop_hold_ms;
      logic signed [15:0] rise_threshold_mv;
   } ctd_cfg_type;

   typedef struct packed {
      logic        push;
      logic        clear;
      logic [15:0] voltage_mv;
   } ctd_win_ctl_type;

   typedef struct packed {
      logic        primed;
      logic [15:0] oldest_mv;
   } ctd_win_type;

endpackage

// ===== hw/rtl/ctd_window.sv =====
module ctd_window
   import ctd_pkg::*;
#(
   parameter int unsigned WINDOW_SAMPLES = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  ctd_win_ctl_type ctl,
   output ctd_win_type     status
);

   localparam int unsigned FILL_W = $clog2(WINDOW_SAMPLES + 1);

   logic [15:0]       tap_ff [WINDOW_SAMPLES-1];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         tap_ff[0] <= ctl.voltage_mv;
      end
   end

   for (genvar g = 1; g < WINDOW_SAMPLES - 1; g++) begin : g_tap
      always_ff @(posedge clock) begin
         if (ctl.push) begin
            tap_ff[g] <= tap_ff[g-1];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.clear) begin
         fill_in = '0;
      end else if (ctl.push && fill_ff != FILL_W'(WINDOW_SAMPLES)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // A push that finds all but one slot filled completes the window.
   assign status.primed    = fill_ff >= FILL_W'(WINDOW_SAMPLES - 1);
   assign status.oldest_mv = tap_ff[WINDOW_SAMPLES-2];

endmodule

// ===== hw/rtl/ctd_csr.sv =====
module ctd_csr
   import ctd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output ctd_cfg_type           cfg
);

   ctd_cfg_type   cfg_ff;
   ctd_cfg_type   cfg_in;
   reg_index_type index;
   logic          write;

   assign index = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_BLINK_PERIOD:   cfg_in.blink_period_ms   = csr_pwdata[15:0];
            REG_PERCENT_PERIOD: cfg_in.percent_period_ms = csr_pwdata[15:0];
            REG_SAMPLE_PERIOD:  cfg_in.sample_period_ms  = csr_pwdata[15:0];
            REG_GUARD:          cfg_in.guard_ms          = csr_pwdata[15:0];
            REG_STOP_HOLD:      cfg_in.stop_hold_ms      = csr_pwdata[15:0];
            REG_RISE_THRESHOLD: cfg_in.rise_threshold_mv = signed'(csr_pwdata[15:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_period_ms   <= BLINK_PERIOD_RESET;
         cfg_ff.percent_period_ms <= PERCENT_PERIOD_RESET;
         cfg_ff.sample_period_ms  <= SAMPLE_PERIOD_RESET;
         cfg_ff.guard_ms          <= GUARD_RESET;
         cfg_ff.stop_hold_ms      <= STOP_HOLD_RESET;
         cfg_ff.rise_threshold_mv <= signed'(RISE_THRESHOLD_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_BLINK_PERIOD:   csr_prdata = {16'b0, cfg_ff.blink_period_ms};
         REG_PERCENT_PERIOD: csr_prdata = {16'b0, cfg_ff.percent_period_ms};
         REG_SAMPLE_PERIOD:  csr_prdata = {16'b0, cfg_ff.sample_period_ms};
         REG_GUARD:          csr_prdata = {16'b0, cfg_ff.guard_ms};
         REG_STOP_HOLD:      csr_prdata = {16'b0, cfg_ff.stop_hold_ms};
         REG_RISE_THRESHOLD: csr_prdata = {{16{cfg_ff.rise_threshold_mv[15]}},
                                           cfg_ff.rise_threshold_mv};
         default:            csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== hw/rtl/ctd_core.sv =====
module ctd_core
   import ctd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  ctd_req_type     item,
   input  ctd_cfg_type     cfg,
   input  ctd_win_type     win,
   output ctd_win_ctl_type win_ctl,
   output ctd_rsp_type     result
);

   logic        charging_ff, charging_in;
   logic        bright_ff, bright_in;
   logic        auto_ff, auto_in;
   logic [31:0] last_blink_ff, last_blink_in;
   logic [31:0] last_refresh_ff, last_refresh_in;
   logic [31:0] last_sample_ff, last_sample_in;
   logic [31:0] last_rise_ff, last_rise_in;
   logic [31:0] guard_until_ff, guard_until_in;
   logic [7:0]  shown_ff, shown_in;

   logic [7:0]         pct;
   logic               blink_due;
   logic               refresh_due;
   logic               sample_due;
   logic               stop_due;
   logic               guarded;
   logic signed [16:0] delta;
   logic signed [16:0] threshold;
   logic               rise;
   logic               reported;
   logic               push;
   logic               clear;

   assign pct         = (item.battery_percent > PERCENT_MAX) ? PERCENT_MAX
                                                              : item.battery_percent;
   assign blink_due   = (item.now_ms - last_blink_ff)   >= {16'b0, cfg.blink_period_ms};
   assign refresh_due = (item.now_ms - last_refresh_ff) >= {16'b0, cfg.percent_period_ms};
   assign sample_due  = (item.now_ms - last_sample_ff)  >= {16'b0, cfg.sample_period_ms};
   assign stop_due    = (item.now_ms - last_rise_ff)    >= {16'b0, cfg.stop_hold_ms};
   assign guarded     = item.now_ms < guard_until_ff;
   assign delta       = signed'({1'b0, item.voltage_mv}) - signed'({1'b0, win.oldest_mv});
   assign threshold   = 17'(cfg.rise_threshold_mv);
   assign rise        = win.primed && (delta >= threshold);

   always_comb begin
      charging_in     = charging_ff;
      bright_in       = bright_ff;
      auto_in         = auto_ff;
      last_blink_in   = last_blink_ff;
      last_refresh_in = last_refresh_ff;
      last_sample_in  = last_sample_ff;
      last_rise_in    = last_rise_ff;
      guard_until_in  = guard_until_ff;
      shown_in        = shown_ff;
      reported        = 1'b0;
      push            = 1'b0;
      clear           = 1'b0;
      case (op_type'(item.operation))
         OP_HOST: begin
            if (charging_ff == item.enable) begin
               if (!item.enable) begin
                  guard_until_in = item.now_ms + {16'b0, cfg.guard_ms};
               end
            end else begin
               guard_until_in = item.now_ms + {16'b0, cfg.guard_ms};
               charging_in    = item.enable;
               if (item.enable) begin
                  bright_in     = 1'b0;
                  last_blink_in = item.now_ms;
                  shown_in      = pct;
                  reported      = 1'b1;
               end
            end
         end
         OP_AUTO: begin
            auto_in = item.enable;
            if (!item.enable) begin
               clear = 1'b1;
            end else begin
               last_sample_in = item.now_ms;
               last_rise_in   = item.now_ms;
            end
         end
         OP_TICK: begin
            if (charging_ff) begin
               if (blink_due) begin
                  last_blink_in = item.now_ms;
                  bright_in     = !bright_ff;
               end
               if (refresh_due) begin
                  last_refresh_in = item.now_ms;
                  if (pct != shown_ff) begin
                     shown_in = pct;
                     reported = 1'b1;
                  end
               end
            end
            if (auto_ff && sample_due) begin
               last_sample_in = item.now_ms;
               push           = 1'b1;
               if (!guarded) begin
                  if (rise) begin
                     last_rise_in = item.now_ms;
                     if (!charging_ff) begin
                        charging_in   = 1'b1;
                        bright_in     = 1'b0;
                        last_blink_in = item.now_ms;
                        shown_in      = pct;
                        reported      = 1'b1;
                     end
                  end else if (charging_ff && stop_due) begin
                     charging_in = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         charging_ff     <= 1'b0;
         bright_ff       <= 1'b0;
         auto_ff         <= 1'b0;
         last_blink_ff   <= '0;
         last_refresh_ff <= '0;
         last_sample_ff  <= '0;
         last_rise_ff    <= '0;
         guard_until_ff  <= '0;
         shown_ff        <= PERCENT_NONE;
      end else if (go) begin
         charging_ff     <= charging_in;
         bright_ff       <= bright_in;
         auto_ff         <= auto_in;
         last_blink_ff   <= last_blink_in;
         last_refresh_ff <= last_refresh_in;
         last_sample_ff  <= last_sample_in;
         last_rise_ff    <= last_rise_in;
         guard_until_ff  <= guard_until_in;
         shown_ff        <= shown_in;
      end
   end

   assign win_ctl.push       = go && push;
   assign win_ctl.clear      = go && clear;
   assign win_ctl.voltage_mv = item.voltage_mv;

   assign result.charging       = charging_in;
   assign result.bolt_bright    = bright_in;
   assign result.percent_update = reported;
   assign result.percent_value  = (shown_in <= PERCENT_MAX) ? shown_in[6:0] : 7'd0;

endmodule

// ===== hw/rtl/charge_trend_detector_unit.sv =====
// A transaction accepted on req goes to the input register, its result to the result
// register and then to rsp. One transaction per cycle while rsp_ready is high; the two
// registers decouple the channels; all state updates happen in one pass between them.
// Reset is synchronous and active high: it clears the pipeline, the indicator
// state and the window fill, and returns the configuration registers to defaults.
module charge_trend_detector_unit
   import ctd_pkg::*;
#(
   parameter int unsigned WINDOW_SAMPLES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ctd_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ctd_rsp_type           rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic            in_valid_ff, in_valid_in;
   ctd_req_type     in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   ctd_rsp_type     rsp_item_ff;
   logic            advance;
   ctd_cfg_type     cfg;
   ctd_win_ctl_type win_ctl;
   ctd_win_type     win;
   ctd_rsp_type     result;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   ctd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ctd_window #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .status (win)
   );

   ctd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .go      (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .win     (win),
      .win_ctl (win_ctl),
      .result  (result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

// ===== hw/rtl/ctd_checker.sv =====
`include "charge_trend_detector_unit_macros.svh"

module ctd_checker
   import ctd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input ctd_rsp_type rsp_payload
);

   logic prev_charging_ff;
   logic turned_on;
   logic turn_on_shown;

   // Tracks the indicator as last delivered, to spot an off to on transition.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_charging_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         prev_charging_ff <= rsp_payload.charging;
      end
   end

   assign turned_on     = rsp_valid && !prev_charging_ff && rsp_payload.charging;
   assign turn_on_shown = rsp_payload.percent_update && !rsp_payload.bolt_bright;

   `CTD_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && !rsp_ready, rsp_valid)
   `CTD_ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `CTD_ASSERT_NOW(a_percent_in_range, rsp_valid, rsp_payload.percent_value <= 7'd100)
   `CTD_ASSERT_NOW(a_turn_on_reports, turned_on, turn_on_shown)

endmodule

bind charge_trend_detector_unit ctd_checker u_ctd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== bench/charge_trend_detector_unit_test.sv =====
module charge_trend_detector_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ctd_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WINDOW_DEPTH = 8;
   localparam int HEAD_W = $clog2(WINDOW_DEPTH);
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 160;
   localparam int MISMATCH_REPORTS = 10;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_ms;
      logic        enable;
      logic [15:0] voltage_mv;
      logic [7:0]  battery_percent;
      logic        typed;
      ctd_rsp_type result;
   } step_row_type;

   // Host toggling, blink and refresh, then a rising voltage ramp that auto-detect
   // picks up once the guard has expired, a stop on a flat window, and a time wrap.
   localparam step_row_type DIRECTED_STEPS [25] = '{
      '{OP_TICK,   32'd0,          1'b0, 16'd0,     8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 7'd0}},
      '{OP_UNUSED, 32'hFFFF_FFFF,  1'b1, 16'hFFFF,  8'hFF,  1'b1, '{1'b0, 1'b0, 1'b0, 7'd0}},
      '{OP_HOST,   32'd100,        1'b1, 16'd0,     8'd255, 1'b1, '{1'b1, 1'b0, 1'b1, 7'd100}},
      '{OP_HOST,   32'd200,        1'b1, 16'd0,     8'd50,  1'b1, '{1'b1, 1'b0, 1'b0, 7'd100}},
      '{OP_TICK,   32'd600,        1'b0, 16'd0,     8'd0,   1'b1, '{1'b1, 1'b1, 1'b0, 7'd100}},
      '{OP_TICK,   32'd2600,       1'b0, 16'd0,     8'd101, 1'b0, '0},
      '{OP_TICK,   32'd4600,       1'b0, 16'd0,     8'd0,   1'b0, '0},
      '{OP_HOST,   32'd5000,       1'b0, 16'd0,     8'd77,  1'b0, '0},
      '{OP_HOST,   32'd6000,       1'b0, 16'd0,     8'd77,  1'b0, '0},
      '{OP_AUTO,   32'd6000,       1'b1, 16'd0,     8'd77,  1'b0, '0},
      '{OP_TICK,   32'd7000,       1'b0, 16'd0,     8'd100, 1'b0, '0},
      '{OP_TICK,   32'd8000,       1'b0, 16'd100,   8'd100, 1'b0, '0},
      '{OP_TICK,   32'd9000,       1'b0, 16'd200,   8'd100, 1'b0, '0},
      '{OP_TICK,   32'd10000,      1'b0, 16'd300,   8'd100, 1'b0, '0},
      '{OP_TICK,   32'd11000,      1'b0, 16'd400,   8'd100, 1'b0, '0},
      '{OP_TICK,   32'd12000,      1'b0, 16'd500,   8'd100, 1'b0, '0},
      '{OP_TICK,   32'd13000,      1'b0, 16'd600,   8'd100, 1'b0, '0},
      '{OP_TICK,   32'd14000,      1'b0, 16'd700,   8'd100, 1'b0, '0},
      '{OP_TICK,   32'd15000,      1'b1, 16'hFFFF,  8'd255, 1'b0, '0},
      '{OP_TICK,   32'd16000,      1'b0, 16'd0,     8'd42,  1'b0, '0},
      '{OP_TICK,   32'd26000,      1'b0, 16'd0,     8'd42,  1'b0, '0},
      '{OP_AUTO,   32'd26001,      1'b0, 16'd0,     8'd42,  1'b0, '0},
      '{OP_TICK,   32'hFFFF_FFFF,  1'b0, 16'd1234,  8'd100, 1'b0, '0},
      '{OP_HOST,   32'hFFFF_FFFF,  1'b1, 16'd1234,  8'd0,   1'b1, '{1'b1, 1'b0, 1'b1, 7'd0}},
      '{OP_TICK,   32'h0000_0100,  1'b0, 16'd1234,  8'd100, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ctd_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ctd_rsp_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   always #5 clock = ~clock;

   charge_trend_detector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ctd_cfg_type settings = '{BLINK_PERIOD_RESET, PERCENT_PERIOD_RESET, SAMPLE_PERIOD_RESET,
                             GUARD_RESET, STOP_HOLD_RESET, RISE_THRESHOLD_RESET};
   logic lit = 1'b0;
   logic bright = 1'b0;
   logic auto_on = 1'b0;
   logic [31:0] blink_mark = '0;
   logic [31:0] refresh_mark = '0;
   logic [31:0] sample_mark = '0;
   logic [31:0] rise_mark = '0;
   logic [31:0] guard_end = '0;
   logic [7:0] percent_shown = PERCENT_NONE;
   logic [15:0] volt_ring [WINDOW_DEPTH] = '{default: 16'd0};
   logic [HEAD_W-1:0] ring_head = '0;
   logic [HEAD_W:0] ring_fill = '0;
   logic percent_fresh = 1'b0;

   ctd_rsp_type expected_indicators [$];
   int req_calm = 0;
   int rsp_calm = 0;
   bit hold_request = 1'b0;
   int sent_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int register_writes = 0;
   int light_count = 0;
   int auto_off_count = 0;

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic void offer_percent(logic [7:0] raw);
      logic [7:0] clamped;
      clamped = (raw > PERCENT_MAX) ? PERCENT_MAX : raw;
      if (clamped != percent_shown) begin
         percent_shown = clamped;
         percent_fresh = 1'b1;
      end
   endfunction

   function automatic void light_bolt(logic [31:0] now, logic [7:0] raw);
      lit = 1'b1;
      bright = 1'b0;
      blink_mark = now;
      percent_shown = PERCENT_NONE;
      offer_percent(raw);
      light_count++;
   endfunction

   function automatic ctd_rsp_type predict_indicator(ctd_req_type item);
      ctd_rsp_type result;
      logic [31:0] now;
      logic [HEAD_W-1:0] newest;
      logic rise;
      int swing;
      now = item.now_ms;
      percent_fresh = 1'b0;
      case (item.operation)
         OP_HOST: begin
            if (lit == item.enable) begin
               if (!item.enable) guard_end = now + 32'(settings.guard_ms);
            end else begin
               guard_end = now + 32'(settings.guard_ms);
               if (item.enable) light_bolt(now, item.battery_percent);
               else lit = 1'b0;
            end
         end
         OP_AUTO: begin
            auto_on = item.enable;
            if (!item.enable) begin
               ring_fill = '0;
               ring_head = '0;
            end else begin
               sample_mark = now;
               rise_mark = now;
            end
         end
         OP_TICK: begin
            if (lit) begin
               if (now - blink_mark >= 32'(settings.blink_period_ms)) begin
                  blink_mark = now;
                  bright = !bright;
               end
               if (now - refresh_mark >= 32'(settings.percent_period_ms)) begin
                  refresh_mark = now;
                  offer_percent(item.battery_percent);
               end
            end
            if (auto_on && now - sample_mark >= 32'(settings.sample_period_ms)) begin
               sample_mark = now;
               volt_ring[ring_head] = item.voltage_mv;
               ring_head = ring_head + 1'b1;
               if (ring_fill < WINDOW_DEPTH) ring_fill++;
               if (now >= guard_end) begin
                  rise = 1'b0;
                  if (ring_fill >= WINDOW_DEPTH) begin
                     newest = ring_head - 1'b1;
                     swing = int'(volt_ring[newest]) - int'(volt_ring[ring_head]);
                     rise = swing >= int'($signed(settings.rise_threshold_mv));
                  end
                  if (rise) begin
                     rise_mark = now;
                     if (!lit) light_bolt(now, item.battery_percent);
                  end else if (lit && now - rise_mark >= 32'(settings.stop_hold_ms)) begin
                     lit = 1'b0;
                     auto_off_count++;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      result.charging = lit;
      result.bolt_bright = bright;
      result.percent_update = percent_fresh;
      result.percent_value = (percent_shown <= PERCENT_MAX) ? percent_shown[6:0] : 7'd0;
      return result;
   endfunction

   task automatic send_item(ctd_req_type item, logic typed, ctd_rsp_type typed_result);
      ctd_rsp_type predicted;
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_indicator(item);
      expected_indicators.push_back(typed ? typed_result : predicted);
      sent_count++;
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_indicators.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type index, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (index)
         REG_BLINK_PERIOD:   settings.blink_period_ms = value;
         REG_PERCENT_PERIOD: settings.percent_period_ms = value;
         REG_SAMPLE_PERIOD:  settings.sample_period_ms = value;
         REG_GUARD:          settings.guard_ms = value;
         REG_STOP_HOLD:      settings.stop_hold_ms = value;
         REG_RISE_THRESHOLD: settings.rise_threshold_mv = value;
         default: begin
         end
      endcase
      register_writes++;
   endtask

   task automatic apply_settings(ctd_cfg_type plan);
      write_register(REG_BLINK_PERIOD, plan.blink_period_ms);
      write_register(REG_PERCENT_PERIOD, plan.percent_period_ms);
      write_register(REG_SAMPLE_PERIOD, plan.sample_period_ms);
      write_register(REG_GUARD, plan.guard_ms);
      write_register(REG_STOP_HOLD, plan.stop_hold_ms);
      write_register(REG_RISE_THRESHOLD, plan.rise_threshold_mv);
   endtask

   always @(posedge clock) begin
      ctd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_indicators.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS)
               $display("Unexpected result: charging=%0b bright=%0b update=%0b percent=%0d",
                        rsp_payload.charging, rsp_payload.bolt_bright,
                        rsp_payload.percent_update, rsp_payload.percent_value);
         end else begin
            want = expected_indicators.pop_front();
            if (rsp_payload.charging !== want.charging ||
                rsp_payload.bolt_bright !== want.bolt_bright ||
                rsp_payload.percent_update !== want.percent_update ||
                rsp_payload.percent_value !== want.percent_value) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_REPORTS)
                  $display("Mismatch on result %0d: expected %0b/%0b/%0b/%0d, got %0b/%0b/%0b/%0d",
                           checked_count, want.charging, want.bolt_bright,
                           want.percent_update, want.percent_value,
                           rsp_payload.charging, rsp_payload.bolt_bright,
                           rsp_payload.percent_update, rsp_payload.percent_value);
            end
            checked_count++;
         end
      end
   end

   initial begin
      int wait_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            wait_cycles = draw_wait(rsp_calm);
            if (wait_cycles > 0) begin
               rsp_ready <= 1'b0;
               repeat (wait_cycles) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("No transaction for %0d cycles, run stopped", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      ctd_req_type item;
      ctd_rsp_type none;
      ctd_cfg_type plan;
      logic [31:0] sim_ms;
      logic [15:0] level;
      logic [7:0] charge_pct;
      int span;
      int slope;
      int pick;
      none = '0;
      slope = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
         item.operation = DIRECTED_STEPS[i].operation;
         item.now_ms = DIRECTED_STEPS[i].now_ms;
         item.enable = DIRECTED_STEPS[i].enable;
         item.voltage_mv = DIRECTED_STEPS[i].voltage_mv;
         item.battery_percent = DIRECTED_STEPS[i].battery_percent;
         send_item(item, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].result);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle_idle();
         span = 12;
         plan.blink_period_ms = 16'($urandom_range(1, 40));
         plan.percent_period_ms = 16'($urandom_range(1, 80));
         plan.sample_period_ms = 16'($urandom_range(1, 10));
         plan.guard_ms = 16'($urandom_range(0, 100));
         plan.stop_hold_ms = 16'($urandom_range(0, 300));
         plan.rise_threshold_mv = 16'($urandom_range(0, 110) - 30);
         case (phase)
            1: begin
               plan = '{16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'h8000};
               span = 3;
            end
            2: begin
               plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF};
               span = 20000;
            end
            5: begin
               plan = '{16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom)};
               span = 40000;
            end
            default: begin
            end
         endcase
         apply_settings(plan);
         sim_ms = (phase == 0) ? 32'hFFFF_F000 : $urandom;
         level = 16'($urandom);
         charge_pct = 8'($urandom_range(0, 120));
         item = '{OP_HOST, sim_ms, 1'b0, level, charge_pct};
         send_item(item, 1'b0, none);
         item = '{OP_AUTO, sim_ms, 1'b1, level, charge_pct};
         send_item(item, 1'b0, none);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 40) hold_request = 1'b1;
            if (n % 32 == 0) slope = $urandom_range(0, 60) - 20;
            if ($urandom_range(0, 399) == 0) sim_ms = sim_ms + $urandom;
            else sim_ms = sim_ms + $urandom_range(0, span);
            level = level + 16'(slope);
            if ($urandom_range(0, 19) == 0) level = 16'($urandom);
            if ($urandom_range(0, 7) == 0) charge_pct = 8'($urandom);
            item = '{OP_TICK, sim_ms, 1'($urandom), level, charge_pct};
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               item.operation = 2'($urandom);
               item.voltage_mv = 16'($urandom);
               item.battery_percent = 8'($urandom);
            end else if (pick < 5) begin
               item.operation = OP_UNUSED;
            end else if (pick < 11) begin
               item.operation = OP_HOST;
               item.enable = $urandom_range(0, 2) != 0;
            end else if (pick < 16) begin
               item.operation = OP_AUTO;
               item.enable = $urandom_range(0, 3) != 0;
            end
            send_item(item, 1'b0, none);
         end
      end

      settle_idle();
      $display("Run covered %0d transactions (%0d directed) over %0d register writes; %0d results compared.",
               sent_count, $size(DIRECTED_STEPS), register_writes, checked_count);
      $display("Charging was predicted to light %0d times and to stop on a flat trend %0d times.",
               light_count, auto_off_count);
      if (mismatch_count == 0 && expected_indicators.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
